/* sv/dcf_pkg.sv */
package dcf_pkg;

    localparam int ADDR_W        = 64;
    localparam int MAX_NODES_DEF = 32;
    // longest chain emitted for one query
    localparam int MAX_OUT       = 32;
    localparam int K_W           = $clog2(MAX_OUT + 1);

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] edge_from;
        logic [ADDR_W-1:0] edge_to;
        logic [ADDR_W-1:0] func_head;
        logic [ADDR_W-1:0] target_addr;
    } dcf_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] dom_addr;
        logic              last;
        logic              overflow;
    } dcf_out_t;

    // command codes
    localparam logic CMD_EDGE  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

endpackage

/* sv/dcf_ram.sv */
module dcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/dominator_chain_finder_core.sv */
// edge request: table search over the nodes entered, then states that enter new addresses and
// update the predecessor row, or drop the whole edge when the table lacks room; no result
// query request: table search, dominator set init, then a row-by-row fixed-point pass until
// nothing changes, then a dominator scan per chain element plus output stalls; one request in flight
// reset clears control, node count, predecessor row valid bits and the overflow flag;
// the rams are not swept, so the block is ready right after reset
module dominator_chain_finder_core
    import dcf_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dcf_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output dcf_out_t out_data
);

    localparam int N  = MAX_NODES;
    localparam int IW = $clog2(N);
    localparam int CW = $clog2(N + 1);
    localparam logic [N-1:0] ONE = N'(1);

    // sequencer states, one-hot
    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_SRCH   = 15'h0002,
        S_E_FROM = 15'h0004,
        S_E_TO   = 15'h0008,
        S_E_PRD  = 15'h0010,
        S_E_PWR  = 15'h0020,
        S_Q_INIT = 15'h0040,
        S_R_PRD  = 15'h0080,
        S_R_SCAN = 15'h0100,
        S_R_WR   = 15'h0200,
        S_C_SELF = 15'h0400,
        S_C_GET  = 15'h0800,
        S_C_SCAN = 15'h1000,
        S_C_PICK = 15'h2000,
        S_C_EMIT = 15'h4000
    } state_t;

    // control registers
    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic [N-1:0]    pred_vld_reg, pred_vld_next;
    logic            out_vld_reg, out_vld_next;

    // working registers
    logic [ADDR_W-1:0] key_a_reg, key_a_next;     // edge source or function head
    logic [ADDR_W-1:0] key_b_reg, key_b_next;     // edge destination or target
    logic              is_q_reg, is_q_next;
    logic              af_reg, af_next, bf_reg, bf_next;
    logic [IW-1:0]     ai_reg, ai_next, bi_reg, bi_next;
    logic [CW-1:0]     scan_idx_reg, scan_idx_next;
    logic              dv_reg, dv_next;
    logic [IW-1:0]     didx_reg, didx_next;
    logic [IW-1:0]     row_reg, row_next;
    logic              changed_reg, changed_next;
    logic [N-1:0]      meet_reg, meet_next;
    logic [N-1:0]      self_reg, self_next;
    logic [IW-1:0]     cur_reg, cur_next;
    logic [N-1:0]      seen_reg, seen_next;
    logic [K_W-1:0]    k_reg, k_next;
    logic [N-1:0]      doms_reg, doms_next;
    logic [N-1:0]      beaten_reg, beaten_next;
    logic [IW-1:0]     idom_reg, idom_next;
    logic              idv_reg, idv_next;
    logic [ADDR_W-1:0] caddr_reg, caddr_next;
    logic              unk_reg, unk_next;
    dcf_out_t          out_reg, out_next;

    // ram ports
    logic              a_we, a_re;
    logic [IW-1:0]     a_wa, a_ra;
    logic [ADDR_W-1:0] a_wd, a_rdata;
    logic              p_we, p_re;
    logic [IW-1:0]     p_wa, p_ra;
    logic [N-1:0]      p_wd, p_rdata;
    logic              d_we, d_re;
    logic [IW-1:0]     d_wa, d_ra;
    logic [N-1:0]      d_wd, d_rdata;

    // node address table
    dcf_ram #(.WIDTH(ADDR_W), .DEPTH(N)) u_addr_ram (
        .clk     (clk),
        .wr_en   (a_we),
        .wr_addr (a_wa),
        .wr_data (a_wd),
        .rd_en   (a_re),
        .rd_addr (a_ra),
        .rd_data (a_rdata)
    );

    // predecessor rows, a row without its valid bit reads as empty
    dcf_ram #(.WIDTH(N), .DEPTH(N)) u_pred_ram (
        .clk     (clk),
        .wr_en   (p_we),
        .wr_addr (p_wa),
        .wr_data (p_wd),
        .rd_en   (p_re),
        .rd_addr (p_ra),
        .rd_data (p_rdata)
    );

    // dominator sets, rebuilt by every query before use
    dcf_ram #(.WIDTH(N), .DEPTH(N)) u_dom_ram (
        .clk     (clk),
        .wr_en   (d_we),
        .wr_addr (d_wa),
        .wr_data (d_wd),
        .rd_en   (d_re),
        .rd_addr (d_ra),
        .rd_data (d_rdata)
    );

    // helpers
    logic [N-1:0]    full_mask;
    logic            scan_issue, scan_done;
    logic [1:0]      need;
    logic [CW:0]     cnt_sum;
    logic            same_addr;
    logic [N-1:0]    pred_row, nd;
    logic [N-1:0]    cand, low;
    logic [IW-1:0]   low_idx;
    logic            slot_free, more;
    logic            last_row;

    always_comb
    begin
        for (int j = 0; j < N; j++)
        begin
            full_mask[j] = (CW'(j) < cnt_reg);
        end
    end

    // lowest candidate: isolate lowest set bit, then encode the one-hot word
    always_comb
    begin
        cand    = doms_reg & ~(ONE << cur_reg) & ~beaten_reg;
        low     = cand & (~cand + ONE);
        low_idx = '0;
        for (int j = 0; j < N; j++)
        begin
            if (low[j])
            begin
                low_idx = low_idx | IW'(j);
            end
        end
    end

    assign scan_issue = (scan_idx_reg < cnt_reg);
    assign scan_done  = !scan_issue && !dv_reg;
    assign same_addr  = (key_a_reg == key_b_reg);
    assign need       = {1'b0, !af_reg} + {1'b0, (!bf_reg && !(!af_reg && same_addr))};
    assign cnt_sum    = {1'b0, cnt_reg} + (CW+1)'(need);
    assign pred_row   = pred_vld_reg[row_reg] ? p_rdata : '0;
    assign nd         = (self_reg & meet_reg) | (self_reg & (ONE << row_reg));
    assign last_row   = (CW'(row_reg) == (cnt_reg - CW'(1)));
    assign slot_free  = !out_vld_reg || out_ready;
    assign more       = !unk_reg && idv_reg && !seen_reg[idom_reg] &&
                        (k_reg < K_W'(MAX_OUT - 1));

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;
        pred_vld_next = pred_vld_reg;
        out_vld_next  = out_vld_reg && !out_ready;
        out_next      = out_reg;
        key_a_next    = key_a_reg;
        key_b_next    = key_b_reg;
        is_q_next     = is_q_reg;
        af_next       = af_reg;
        bf_next       = bf_reg;
        ai_next       = ai_reg;
        bi_next       = bi_reg;
        scan_idx_next = scan_idx_reg;
        dv_next       = 1'b0;
        didx_next     = scan_idx_reg[IW-1:0];
        row_next      = row_reg;
        changed_next  = changed_reg;
        meet_next     = meet_reg;
        self_next     = self_reg;
        cur_next      = cur_reg;
        seen_next     = seen_reg;
        k_next        = k_reg;
        doms_next     = doms_reg;
        beaten_next   = beaten_reg;
        idom_next     = idom_reg;
        idv_next      = idv_reg;
        caddr_next    = caddr_reg;
        unk_next      = unk_reg;
        a_we = 1'b0; a_wa = cnt_reg[IW-1:0]; a_wd = key_a_reg;
        a_re = 1'b0; a_ra = scan_idx_reg[IW-1:0];
        p_we = 1'b0; p_wa = bi_reg; p_wd = '0;
        p_re = 1'b0; p_ra = bi_reg;
        d_we = 1'b0; d_wa = scan_idx_reg[IW-1:0]; d_wd = full_mask;
        d_re = 1'b0; d_ra = scan_idx_reg[IW-1:0];

        // shared scan pointer: one ram read issued per cycle, data arrives in the next cycle
        if ((state_reg == S_SRCH || state_reg == S_R_SCAN || state_reg == S_C_SCAN) &&
            scan_issue)
        begin
            scan_idx_next = scan_idx_reg + CW'(1);
            dv_next       = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    is_q_next     = in_data.cmd;
                    key_a_next    = (in_data.cmd == CMD_QUERY) ? in_data.func_head
                                                               : in_data.edge_from;
                    key_b_next    = (in_data.cmd == CMD_QUERY) ? in_data.target_addr
                                                               : in_data.edge_to;
                    af_next       = 1'b0;
                    bf_next       = 1'b0;
                    scan_idx_next = '0;
                    state_next    = S_SRCH;
                end
            end
            S_SRCH:
            begin
                a_re = scan_issue;
                if (dv_reg)
                begin
                    if (a_rdata == key_a_reg)
                    begin
                        af_next = 1'b1;
                        ai_next = didx_reg;
                    end
                    if (a_rdata == key_b_reg)
                    begin
                        bf_next = 1'b1;
                        bi_next = didx_reg;
                    end
                end
                if (scan_done)
                begin
                    if (is_q_reg == CMD_QUERY)
                    begin
                        seen_next = '0;
                        k_next    = '0;
                        if (!bf_reg)
                        begin
                            // unknown target: only the target itself comes out
                            unk_next   = 1'b1;
                            state_next = S_C_EMIT;
                        end
                        else
                        begin
                            unk_next      = 1'b0;
                            scan_idx_next = '0;
                            state_next    = S_Q_INIT;
                        end
                    end
                    else if (cnt_sum > (CW+1)'(N))
                    begin
                        // no room in the table: whole edge dropped
                        ovf_next   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (!af_reg)
                    begin
                        state_next = S_E_FROM;
                    end
                    else if (!bf_reg)
                    begin
                        state_next = S_E_TO;
                    end
                    else
                    begin
                        state_next = S_E_PRD;
                    end
                end
            end
            S_E_FROM:
            begin
                a_we     = 1'b1;
                a_wd     = key_a_reg;
                ai_next  = cnt_reg[IW-1:0];
                cnt_next = cnt_reg + CW'(1);
                if (bf_reg)
                begin
                    state_next = S_E_PRD;
                end
                else if (same_addr)
                begin
                    // self loop on a new address: both ends are the new entry
                    bi_next    = cnt_reg[IW-1:0];
                    state_next = S_E_PRD;
                end
                else
                begin
                    state_next = S_E_TO;
                end
            end
            S_E_TO:
            begin
                a_we       = 1'b1;
                a_wd       = key_b_reg;
                bi_next    = cnt_reg[IW-1:0];
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_E_PRD;
            end
            S_E_PRD:
            begin
                p_re       = 1'b1;
                state_next = S_E_PWR;
            end
            S_E_PWR:
            begin
                p_we = 1'b1;
                p_wd = (pred_vld_reg[bi_reg] ? p_rdata : '0) | (ONE << ai_reg);
                pred_vld_next[bi_reg] = 1'b1;
                state_next = S_IDLE;
            end
            S_Q_INIT:
            begin
                d_we = 1'b1;
                if (af_reg && (scan_idx_reg[IW-1:0] == ai_reg))
                begin
                    d_wd = ONE << ai_reg;
                end
                scan_idx_next = scan_idx_reg + CW'(1);
                if (scan_idx_reg == (cnt_reg - CW'(1)))
                begin
                    row_next     = '0;
                    changed_next = 1'b0;
                    state_next   = S_R_PRD;
                end
            end
            S_R_PRD:
            begin
                p_re          = 1'b1;
                p_ra          = row_reg;
                meet_next     = '1;
                scan_idx_next = '0;
                state_next    = S_R_SCAN;
            end
            S_R_SCAN:
            begin
                d_re = scan_issue;
                if (dv_reg)
                begin
                    if (pred_row[didx_reg])
                    begin
                        meet_next = meet_reg & d_rdata;
                    end
                    if (didx_reg == row_reg)
                    begin
                        self_next = d_rdata;
                    end
                end
                if (scan_done)
                begin
                    state_next = S_R_WR;
                end
            end
            S_R_WR:
            begin
                d_wa = row_reg;
                d_wd = nd;
                d_we = (nd != self_reg);
                if (last_row)
                begin
                    row_next     = '0;
                    changed_next = 1'b0;
                    if (changed_reg || (nd != self_reg))
                    begin
                        state_next = S_R_PRD;
                    end
                    else
                    begin
                        cur_next   = bi_reg;
                        state_next = S_C_SELF;
                    end
                end
                else
                begin
                    row_next     = row_reg + IW'(1);
                    changed_next = changed_reg || (nd != self_reg);
                    state_next   = S_R_PRD;
                end
            end
            S_C_SELF:
            begin
                d_re       = 1'b1;
                d_ra       = cur_reg;
                a_re       = 1'b1;
                a_ra       = cur_reg;
                state_next = S_C_GET;
            end
            S_C_GET:
            begin
                doms_next     = d_rdata;
                caddr_next    = a_rdata;
                beaten_next   = '0;
                scan_idx_next = '0;
                state_next    = S_C_SCAN;
            end
            S_C_SCAN:
            begin
                // a strict dominator that dominates another strict dominator is beaten
                d_re = scan_issue;
                if (dv_reg && doms_reg[didx_reg] && (didx_reg != cur_reg))
                begin
                    beaten_next = beaten_reg | (d_rdata & ~(ONE << didx_reg));
                end
                if (scan_done)
                begin
                    state_next = S_C_PICK;
                end
            end
            S_C_PICK:
            begin
                idom_next  = low_idx;
                idv_next   = (cand != '0);
                state_next = S_C_EMIT;
            end
            S_C_EMIT:
            begin
                if (slot_free)
                begin
                    out_vld_next      = 1'b1;
                    out_next.dom_addr = unk_reg ? key_b_reg : caddr_reg;
                    out_next.last     = !more;
                    out_next.overflow = ovf_reg;
                    seen_next         = seen_reg | (ONE << cur_reg);
                    k_next            = k_reg + K_W'(1);
                    if (more)
                    begin
                        cur_next   = idom_reg;
                        state_next = S_C_SELF;
                    end
                    else
                    begin
                        // graph cleared after every query
                        cnt_next      = '0;
                        pred_vld_next = '0;
                        ovf_next      = 1'b0;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            ovf_reg      <= 1'b0;
            pred_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ovf_reg      <= ovf_next;
            pred_vld_reg <= pred_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        key_a_reg    <= key_a_next;
        key_b_reg    <= key_b_next;
        is_q_reg     <= is_q_next;
        af_reg       <= af_next;
        bf_reg       <= bf_next;
        ai_reg       <= ai_next;
        bi_reg       <= bi_next;
        scan_idx_reg <= scan_idx_next;
        dv_reg       <= dv_next;
        didx_reg     <= didx_next;
        row_reg      <= row_next;
        changed_reg  <= changed_next;
        meet_reg     <= meet_next;
        self_reg     <= self_next;
        cur_reg      <= cur_next;
        seen_reg     <= seen_next;
        k_reg        <= k_next;
        doms_reg     <= doms_next;
        beaten_reg   <= beaten_next;
        idom_reg     <= idom_next;
        idv_reg      <= idv_next;
        caddr_reg    <= caddr_next;
        unk_reg      <= unk_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

`ifndef SYNTH
    // node table never holds more entries than it has
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(N))
        else $error("node count beyond table size");

    // a new result only appears out of the emit state
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == S_C_EMIT))
        else $error("result loaded outside emit");

    // the chain never revisits a node
    a_no_revisit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_C_SELF) |-> !seen_reg[cur_reg])
        else $error("chain revisits a node");

    // the final element clears the graph
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_C_EMIT && slot_free && !more) |=>
            (cnt_reg == '0 && pred_vld_reg == '0 && !ovf_reg))
        else $error("graph not cleared after query");

    // chain length bounded
    a_chain_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_C_EMIT) |-> (k_reg < K_W'(MAX_OUT)))
        else $error("chain longer than limit");
`endif

endmodule

/* bench/dcf_chain_checker.sv */
`timescale 1ns / 1ps

module dcf_chain_checker
    import dcf_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  dcf_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  dcf_out_t out_data,
    output int       errors,
    output int       pending,
    output int       queries,
    output int       results
);

    // shadow copy of the graph
    logic [ADDR_W-1:0] node_tbl [MAX_NODES];
    int                node_cnt;
    logic [63:0]       pred_rows [MAX_NODES];
    logic [63:0]       dom_rows [MAX_NODES];
    int                idom_of [MAX_NODES];
    logic [63:0]       idom_ok;
    logic              ovf_seen;

    dcf_out_t chain_q [$];

    function automatic int find_node(logic [ADDR_W-1:0] a);
        for (int i = 0; i < node_cnt; i++)
            if (node_tbl[i] == a)
                return i;
        return -1;
    endfunction

    task automatic add_edge(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst);
        int fi;
        int ti;
        int need;
        fi = find_node(src);
        ti = find_node(dst);
        need = 0;
        if (fi < 0)
            need++;
        if (ti < 0 && !(fi < 0 && src == dst))
            need++;
        if (node_cnt + need > MAX_NODES)
        begin
            ovf_seen = 1'b1;
            return;
        end
        if (fi < 0)
        begin
            node_tbl[node_cnt] = src;
            fi = node_cnt;
            node_cnt++;
        end
        if (ti < 0)
        begin
            ti = find_node(dst);
            if (ti < 0)
            begin
                node_tbl[node_cnt] = dst;
                ti = node_cnt;
                node_cnt++;
            end
        end
        pred_rows[ti][fi] = 1'b1;
    endtask

    task automatic solve_dominators(int hi);
        logic [63:0] full;
        logic [63:0] meet;
        logic [63:0] nd;
        bit          changed;
        bit          beaten;
        full = (64'd1 << node_cnt) - 64'd1;
        for (int i = 0; i < node_cnt; i++)
            dom_rows[i] = full;
        if (hi >= 0)
            dom_rows[hi] = 64'd1 << hi;
        changed = 1;
        while (changed)
        begin
            changed = 0;
            for (int i = 0; i < node_cnt; i++)
            begin
                meet = '1;
                for (int p = 0; p < node_cnt; p++)
                    if (pred_rows[i][p])
                        meet &= dom_rows[p];
                nd = (dom_rows[i] & meet) | (dom_rows[i] & (64'd1 << i));
                if (nd != dom_rows[i])
                begin
                    dom_rows[i] = nd;
                    changed = 1;
                end
            end
        end
        // nearest strict dominator, lowest index wins
        idom_ok = '0;
        for (int i = 0; i < node_cnt; i++)
        begin
            if (i == hi)
                continue;
            for (int d = 0; d < node_cnt; d++)
            begin
                if (d == i || !dom_rows[i][d])
                    continue;
                beaten = 0;
                for (int p = 0; p < node_cnt; p++)
                    if (p != d && p != i && dom_rows[i][p] && dom_rows[p][d])
                        beaten = 1;
                if (!beaten)
                begin
                    idom_of[i] = d;
                    idom_ok[i] = 1'b1;
                    break;
                end
            end
        end
    endtask

    task automatic run_query(logic [ADDR_W-1:0] head, logic [ADDR_W-1:0] tgt);
        int          hi;
        int          ti;
        int          cur;
        int          k;
        bit          more;
        logic [63:0] seen;
        dcf_out_t    r;
        hi = find_node(head);
        ti = find_node(tgt);
        if (ti < 0)
        begin
            r.dom_addr = tgt;
            r.last     = 1'b1;
            r.overflow = ovf_seen;
            chain_q = {chain_q, r};
        end
        else
        begin
            solve_dominators(hi);
            seen = '0;
            cur = ti;
            k = 0;
            while (1)
            begin
                seen[cur] = 1'b1;
                k++;
                more = idom_ok[cur] && !seen[idom_of[cur]] && k < MAX_OUT;
                r.dom_addr = node_tbl[cur];
                r.last     = !more;
                r.overflow = ovf_seen;
                chain_q = {chain_q, r};
                if (!more)
                    break;
                cur = idom_of[cur];
            end
        end
        node_cnt = 0;
        for (int i = 0; i < MAX_NODES; i++)
            pred_rows[i] = '0;
        ovf_seen = 1'b0;
        idom_ok = '0;
    endtask

    task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                   logic [ADDR_W-1:0] want);
        $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        queries = 0;
        results = 0;
        pending = 0;
        node_cnt = 0;
        ovf_seen = 1'b0;
        idom_ok = '0;
        for (int i = 0; i < MAX_NODES; i++)
            pred_rows[i] = '0;
    end

    always @(posedge clk)
    begin
        dcf_out_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (in_data.cmd == CMD_QUERY)
                begin
                    run_query(in_data.func_head, in_data.target_addr);
                    queries++;
                end
                else
                    add_edge(in_data.edge_from, in_data.edge_to);
            end
            if (out_valid && out_ready)
            begin
                results++;
                if (chain_q.size() == 0)
                    report_mismatch("unexpected result", out_data.dom_addr, '0);
                else
                begin
                    want = chain_q.pop_front();
                    if (out_data.dom_addr !== want.dom_addr)
                        report_mismatch("dom_addr", out_data.dom_addr, want.dom_addr);
                    if (out_data.last !== want.last)
                        report_mismatch("last", out_data.last, want.last);
                    if (out_data.overflow !== want.overflow)
                        report_mismatch("overflow", out_data.overflow, want.overflow);
                end
            end
        end
        pending <= chain_q.size();
    end

endmodule

/* bench/tb_dominator_chain_finder_core.sv */
`timescale 1ns / 1ps

module tb_dominator_chain_finder_core;
    import dcf_pkg::*;

    // cycles with no handshake on either side before giving up
    localparam int STALL_LIMIT = 400000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    dcf_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    dcf_out_t out_data;

    int errors;
    int pending;
    int queries;
    int results;

    // idling knobs, percent per cycle
    int send_idle_pct;
    int recv_stall_pct;
    // long receiver hold-off, armed by the stimulus
    bit hold_go;
    int hold_left;

    int sent;
    int idle_cycles;

    dominator_chain_finder_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // predicts every chain and compares it beat by beat
    dcf_chain_checker u_chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .errors   (errors),
        .pending  (pending),
        .queries  (queries),
        .results  (results)
    );

    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    // receiver side: random stalls, plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_go = 1'b0;
            hold_left = 3000;
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog: counts cycles where neither channel moves
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_dominator_chain_finder_core: errors");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] rand_addr();
        // mix full-range addresses with a few tiny ones
        if ($urandom_range(0, 7) == 0)
            return ADDR_W'($urandom_range(0, 15));
        return {$urandom, $urandom};
    endfunction

    function automatic dcf_in_t edge_req(logic [ADDR_W-1:0] src, logic [ADDR_W-1:0] dst);
        dcf_in_t r;
        r.cmd         = CMD_EDGE;
        r.edge_from   = src;
        r.edge_to     = dst;
        r.func_head   = {$urandom, $urandom};
        r.target_addr = {$urandom, $urandom};
        return r;
    endfunction

    function automatic dcf_in_t query_req(logic [ADDR_W-1:0] head, logic [ADDR_W-1:0] tgt);
        dcf_in_t r;
        r.cmd         = CMD_QUERY;
        r.edge_from   = {$urandom, $urandom};
        r.edge_to     = {$urandom, $urandom};
        r.func_head   = head;
        r.target_addr = tgt;
        return r;
    endfunction

    // present one request and hold it until the block takes it
    task automatic offer(dcf_in_t req);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    // stop offering and wait until every predicted result has come out
    task automatic drain_all();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
    endtask

    // one graph plus its query
    // shape 0: random spanning tree with extra edges, shape 1: straight line
    task automatic graph_and_query(int n, int extra, int shape);
        logic [ADDR_W-1:0] pool [48];
        logic [ADDR_W-1:0] head;
        logic [ADDR_W-1:0] tgt;
        for (int i = 0; i < n; i++)
            pool[i] = rand_addr();
        for (int i = 1; i < n; i++)
            offer(edge_req(shape == 1 ? pool[i-1] : pool[$urandom_range(0, i - 1)], pool[i]));
        // extra edges bring joins, loops and back edges
        for (int e = 0; e < extra; e++)
            offer(edge_req(pool[$urandom_range(0, n - 1)], pool[$urandom_range(0, n - 1)]));
        head = ($urandom_range(0, 9) == 0) ? rand_addr() : pool[0];
        if (shape == 1)
            tgt = pool[n-1];
        else if ($urandom_range(0, 9) == 0)
            tgt = rand_addr();
        else
            tgt = pool[$urandom_range(0, n - 1)];
        offer(query_req(head, tgt));
    endtask

    initial
    begin
        int r;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        hold_go = 1'b0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sent = 0;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: address extremes, self loop, duplicate edge
        offer(edge_req('0, '1));
        offer(edge_req('1, '1));
        offer(edge_req('0, '1));
        offer(edge_req('0, 64'h5));
        offer(edge_req(64'h5, '1));
        offer(query_req('0, '1));
        // unknown target on an empty graph
        offer(query_req('0, 64'h1234));
        // unknown target on a populated graph, then unknown head with a loop
        offer(edge_req(64'h10, 64'h20));
        offer(query_req(64'h10, 64'h99));
        offer(edge_req(64'h1, 64'h2));
        offer(edge_req(64'h2, 64'h3));
        offer(edge_req(64'h3, 64'h1));
        offer(query_req(64'h77, 64'h3));
        // diamond: two paths from the head merge again at the target
        offer(edge_req(64'hA, 64'hB));
        offer(edge_req(64'hA, 64'hC));
        offer(edge_req(64'hB, 64'hD));
        offer(edge_req(64'hC, 64'hD));
        offer(query_req(64'hA, 64'hD));
        // query on the head itself, all-ones head
        offer(edge_req('1, 64'h0));
        offer(query_req('1, '1));
        drain_all();

        // random part, one idling mode per phase
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            while (sent < 20 + (phase + 1) * 75)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    graph_and_query(32, 0, 1);            // chain reaches the length limit
                else if (r < 8)
                    graph_and_query(36, 2, 0);            // table overflows
                else if (r < 15)
                    graph_and_query($urandom_range(2, 4), $urandom_range(0, 2), 0);
                else if (r < 20)
                    offer(query_req(rand_addr(), rand_addr()));   // noise
                else
                    graph_and_query($urandom_range(2, 8), $urandom_range(0, 5), 0);
                if (phase == 0 && r < 30 && hold_left == 0)
                    hold_go = 1'b1;                       // receiver backs off, sender keeps going
                if (phase == 3 && r > 90)
                    drain_all();                          // sender drains the block
            end
        end

        drain_all();
        repeat (200) @(posedge clk);

        $display("covered %0d requests, %0d queries, %0d chain results checked",
                 sent, queries, results);
        $display("idling phases: none, sender gaps, receiver stalls, both; plus long hold-off");
        if (errors == 0)
            $display("tb_dominator_chain_finder_core: clean");
        else
            $display("tb_dominator_chain_finder_core: errors");
        $finish;
    end

endmodule
